[rtl/core/i2cseq_pkg.sv]
// Package for the I2C master transaction sequencer: payload and state types,
// operation and segment codes, and the per-operation segment scripts.
// No dependencies.
package i2cseq_pkg;

  typedef enum logic [2:0] {
    OP_WR1   = 3'd0,
    OP_WR2   = 3'd1,
    OP_RD1   = 3'd2,
    OP_WRRD  = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    SEG_NONE  = 4'd0,
    SEG_START = 4'd1,
    SEG_ADDRW = 4'd2,
    SEG_ADDRR = 4'd3,
    SEG_ACK   = 4'd4,
    SEG_COND  = 4'd5,
    SEG_B1    = 4'd6,
    SEG_B2    = 4'd7,
    SEG_RDB   = 4'd8,
    SEG_NACK  = 4'd9,
    SEG_STOP  = 4'd10,
    SEG_CLR   = 4'd11,
    SEG_CHK   = 4'd12
  } seg_e;

  typedef enum logic [0:0] {
    CFG_IGNORE_NAK = 1'b0,
    CFG_HIGH_HOLD  = 1'b1
  } cfg_idx_e;

  // Steps of one bit slot
  localparam logic [2:0] BIT_DRIVE   = 3'd0;
  localparam logic [2:0] BIT_SAMPLE  = 3'd1;
  localparam logic [2:0] BIT_HOLD    = 3'd2;
  localparam logic [2:0] BIT_LOW     = 3'd3;
  localparam logic [2:0] BIT_RELEASE = 3'd4;

  localparam logic [3:0] ClearLoops = 4'd10;
  localparam logic [3:0] ByteBits   = 4'd8;

  typedef struct packed {
    logic       request_valid;
    logic [2:0] operation;
    logic [6:0] slave_address;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       status;
    logic [7:0] read_data;
  } res_t;

  typedef struct packed {
    logic [3:0] phase;
    logic [2:0] micro;
    logic [3:0] bit_count;
    logic [7:0] shift_byte;
    logic [7:0] hold_count;
    logic [3:0] stop_count;
    logic [2:0] op;
    logic [6:0] addr;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic       last_status;
    logic [7:0] read_byte;
    logic       scl;
    logic       sda;
  } seq_state_t;

  localparam seq_state_t StateReset = '{
    phase: 4'd0, micro: 3'd0, bit_count: 4'd0, shift_byte: 8'd0,
    hold_count: 8'd0, stop_count: 4'd0, op: 3'd0, addr: 7'd0,
    byte_one: 8'd0, byte_two: 8'd0, last_status: 1'b0, read_byte: 8'd0,
    scl: 1'b1, sda: 1'b1
  };

  function automatic logic [3:0] script_len(logic [2:0] op);
    logic [3:0] len;
    unique case (op)
      OP_WR1:   len = 4'd7;
      OP_WR2:   len = 4'd10;
      OP_RD1:   len = 4'd7;
      OP_WRRD:  len = 4'd14;
      OP_CLEAR: len = 4'd2;
      default:  len = 4'd1;
    endcase
    return len;
  endfunction

  // Segment at script position pos (phase - 1)
  function automatic seg_e seg_at(logic [2:0] op, logic [3:0] pos);
    seg_e seg;
    seg = SEG_NONE;
    unique case (op)
      OP_WR1: begin
        unique case (pos)
          4'd0: seg = SEG_START;
          4'd1: seg = SEG_ADDRW;
          4'd2: seg = SEG_ACK;
          4'd3: seg = SEG_COND;
          4'd4: seg = SEG_B1;
          4'd5: seg = SEG_ACK;
          4'd6: seg = SEG_STOP;
          default: seg = SEG_NONE;
        endcase
      end
      OP_WR2: begin
        unique case (pos)
          4'd0: seg = SEG_START;
          4'd1: seg = SEG_ADDRW;
          4'd2: seg = SEG_ACK;
          4'd3: seg = SEG_COND;
          4'd4: seg = SEG_B1;
          4'd5: seg = SEG_ACK;
          4'd6: seg = SEG_COND;
          4'd7: seg = SEG_B2;
          4'd8: seg = SEG_ACK;
          4'd9: seg = SEG_STOP;
          default: seg = SEG_NONE;
        endcase
      end
      OP_RD1: begin
        unique case (pos)
          4'd0: seg = SEG_START;
          4'd1: seg = SEG_ADDRR;
          4'd2: seg = SEG_ACK;
          4'd3: seg = SEG_COND;
          4'd4: seg = SEG_RDB;
          4'd5: seg = SEG_NACK;
          4'd6: seg = SEG_STOP;
          default: seg = SEG_NONE;
        endcase
      end
      OP_WRRD: begin
        unique case (pos)
          4'd0:  seg = SEG_START;
          4'd1:  seg = SEG_ADDRW;
          4'd2:  seg = SEG_ACK;
          4'd3:  seg = SEG_COND;
          4'd4:  seg = SEG_B1;
          4'd5:  seg = SEG_ACK;
          4'd6:  seg = SEG_COND;
          4'd7:  seg = SEG_START;
          4'd8:  seg = SEG_ADDRR;
          4'd9:  seg = SEG_ACK;
          4'd10: seg = SEG_COND;
          4'd11: seg = SEG_RDB;
          4'd12: seg = SEG_NACK;
          4'd13: seg = SEG_STOP;
          default: seg = SEG_NONE;
        endcase
      end
      OP_CLEAR: begin
        unique case (pos)
          4'd0: seg = SEG_CLR;
          4'd1: seg = SEG_CHK;
          default: seg = SEG_NONE;
        endcase
      end
      default: seg = SEG_NONE;
    endcase
    return seg;
  endfunction

endpackage

[rtl/core/i2cseq_stream_if.sv]
// Valid/ready stream interface used for the tick request and result channels.
// The payload type is set per instance from i2cseq_pkg.
interface i2cseq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/i2c_master_transaction_sequencer_core.sv]
// I2C master transaction sequencer: one request is one bus tick, one result per tick.
// A request is registered in the input stage, then its result in the result stage.
// Throughput: one request per cycle while results drain; one state step per request.
// Reset (rst_ni low, asynchronous): idle, SCL and SDA released, status and read
// data zero, configuration zero, both stream stages empty. Uses i2cseq_pkg,
// i2cseq_stream_if and i2cseq_step.
module i2c_master_transaction_sequencer_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  i2cseq_pkg::cfg_idx_e    cfg_idx_i,
  input  logic [7:0]              cfg_wdata_i,
  i2cseq_stream_if.sink           req_i,
  i2cseq_stream_if.source         res_o
);
  import i2cseq_pkg::*;

  // Configuration registers
  logic       ignore_nak_q;
  logic [7:0] high_hold_q;

  // Input stage: holds one tick request until the result slot can take it
  logic       in_vld_q;
  req_t       in_q;

  // Sequencer state
  seq_state_t state_q;
  seq_state_t state_d;

  // Result stage
  logic       out_vld_q;
  res_t       out_q;
  res_t       out_d;

  logic       advance;

  // Advance when a request is held and the result slot is free or being drained
  assign advance     = in_vld_q && (!out_vld_q || res_o.ready);
  assign req_i.ready = !in_vld_q || advance;

  assign res_o.valid   = out_vld_q;
  assign res_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_nak_q <= 1'b0;
      high_hold_q  <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IGNORE_NAK: ignore_nak_q <= cfg_wdata_i[0];
        CFG_HIGH_HOLD:  high_hold_q  <= cfg_wdata_i;
        default:        ignore_nak_q <= ignore_nak_q;
      endcase
    end
  end

  // Input stage: capture a request whenever the slot is free or emptying
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= req_i.payload;
    end
  end

  // One bus action per tick
  i2cseq_step u_step (
    .state_i      (state_q),
    .req_i        (in_q),
    .ignore_nak_i (ignore_nak_q),
    .high_hold_i  (high_hold_q),
    .state_o      (state_d),
    .res_o        (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result stage: hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

endmodule

[rtl/core/i2cseq_step.sv]
// One bus tick of the sequencer: next state and result from the current state,
// the configuration and one tick request. Purely combinational; uses i2cseq_pkg.
module i2cseq_step (
  input  i2cseq_pkg::seq_state_t state_i,
  input  i2cseq_pkg::req_t       req_i,
  input  logic                   ignore_nak_i,
  input  logic [7:0]             high_hold_i,
  output i2cseq_pkg::seq_state_t state_o,
  output i2cseq_pkg::res_t       res_o
);
  import i2cseq_pkg::*;

  seq_state_t n;
  seg_e       seg;
  seg_e       nxt_seg;
  logic       rd;
  logic [3:0] nbits;
  logic       ended;
  logic       busy;
  logic       done;

  always_comb begin
    n       = state_i;
    seg     = SEG_NONE;
    nxt_seg = SEG_NONE;
    rd      = 1'b0;
    nbits   = ByteBits;
    ended   = 1'b0;
    busy    = 1'b0;
    done    = 1'b0;

    // Latch a new transaction; its first segment is never a condition
    if (n.phase == 4'd0 && req_i.request_valid && req_i.operation <= OP_CLEAR) begin
      n.op         = req_i.operation;
      n.addr       = req_i.slave_address;
      n.byte_one   = req_i.first_byte;
      n.byte_two   = req_i.second_byte;
      n.phase      = 4'd1;
      n.micro      = 3'd0;
      n.bit_count  = 4'd0;
      n.stop_count = 4'd0;
    end

    if (n.phase != 4'd0) begin
      busy  = 1'b1;
      seg   = seg_at(n.op, n.phase - 4'd1);
      rd    = (seg == SEG_ACK) || (seg == SEG_RDB);
      nbits = ((seg == SEG_ACK) || (seg == SEG_NACK)) ? 4'd1 : ByteBits;

      unique case (seg)
        SEG_START: begin
          unique case (n.micro)
            3'd0:    n.sda = 1'b1;
            3'd1:    n.scl = 1'b1;
            3'd2:    n.sda = 1'b0;
            default: begin
              n.scl = 1'b0;
              ended = 1'b1;
            end
          endcase
          if (!ended) n.micro = n.micro + 3'd1;
        end
        SEG_STOP: begin
          unique case (n.micro)
            3'd0:    n.sda = 1'b0;
            3'd1:    n.scl = 1'b1;
            default: begin
              n.sda = 1'b1;
              ended = 1'b1;
            end
          endcase
          if (!ended) n.micro = n.micro + 3'd1;
        end
        SEG_CLR: begin
          unique case (n.micro)
            3'd0: begin
              n.scl   = 1'b0;
              n.micro = 3'd1;
            end
            3'd1: begin
              n.sda   = 1'b0;
              n.micro = 3'd2;
            end
            3'd2: begin
              n.scl   = 1'b1;
              n.micro = 3'd3;
            end
            default: begin
              n.sda        = 1'b1;
              n.stop_count = n.stop_count + 4'd1;
              n.micro      = 3'd0;
              ended        = (n.stop_count >= ClearLoops);
            end
          endcase
        end
        SEG_CHK: begin
          n.last_status = ~req_i.sda_in;
          ended         = 1'b1;
        end
        default: begin
          // Bit slots of address, data, acknowledge and read bytes
          unique case (n.micro)
            BIT_DRIVE: begin
              if (rd) n.scl = 1'b1;
              else    n.sda = (seg == SEG_NACK) ? 1'b1 : n.shift_byte[7];
              n.micro = BIT_SAMPLE;
            end
            BIT_SAMPLE: begin
              if (seg == SEG_ACK)      n.last_status = req_i.sda_in;
              else if (seg == SEG_RDB) n.shift_byte  = {n.shift_byte[6:0], req_i.sda_in};
              else                     n.scl         = 1'b1;
              n.hold_count = high_hold_i;
              n.micro      = (high_hold_i != 8'd0) ? BIT_HOLD : BIT_LOW;
            end
            BIT_HOLD: begin
              n.hold_count = n.hold_count - 8'd1;
              if (n.hold_count == 8'd0) n.micro = BIT_LOW;
            end
            BIT_LOW: begin
              n.scl = 1'b0;
              if (!rd) n.shift_byte = {n.shift_byte[6:0], 1'b0};
              n.bit_count = n.bit_count + 4'd1;
              if (n.bit_count < nbits) begin
                n.micro = BIT_DRIVE;
              end else if (seg == SEG_RDB) begin
                n.read_byte = n.shift_byte;
                ended       = 1'b1;
              end else if ((seg == SEG_ACK) || (seg == SEG_NACK)) begin
                ended = 1'b1;
              end else begin
                n.micro = BIT_RELEASE;
              end
            end
            default: begin
              n.sda = 1'b1;
              ended = 1'b1;
            end
          endcase
        end
      endcase

      if (ended) begin
        if (n.phase >= script_len(n.op)) begin
          n.phase = 4'd0;
          n.micro = 3'd0;
          done    = 1'b1;
        end else begin
          n.phase = n.phase + 4'd1;
          // Resolve a condition: go on after an ACK or with NAKs ignored, else jump to the stop
          if (seg_at(n.op, n.phase - 4'd1) == SEG_COND) begin
            if (!n.last_status || ignore_nak_i) n.phase = n.phase + 4'd1;
            else                                n.phase = script_len(n.op);
          end
          n.micro      = 3'd0;
          n.bit_count  = 4'd0;
          n.stop_count = 4'd0;
          nxt_seg      = seg_at(n.op, n.phase - 4'd1);
          unique case (nxt_seg)
            SEG_ADDRW: n.shift_byte = {n.addr, 1'b0};
            SEG_ADDRR: n.shift_byte = {n.addr, 1'b1};
            SEG_B1:    n.shift_byte = n.byte_one;
            SEG_B2:    n.shift_byte = n.byte_two;
            SEG_RDB:   n.shift_byte = 8'd0;
            default:   n.shift_byte = n.shift_byte;
          endcase
        end
      end
    end

    state_o = n;
    res_o   = '{scl_out: n.scl, sda_out: n.sda, busy_res: busy, done_res: done,
                status: n.last_status, read_data: n.read_byte};
  end

endmodule

[sim/tb_i2c_master_transaction_sequencer_core.sv]
// Testbench for the I2C master transaction sequencer core: feeds bus ticks that carry
// I2C transactions, predicts every field of every tick's result and checks them.
// Depends on i2cseq_pkg, i2cseq_stream_if and i2c_master_transaction_sequencer_core.
module tb_i2c_master_transaction_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cseq_pkg::*;

  // Give up after this many cycles in which neither channel moves a request
  localparam int unsigned StallLimit    = 3000;
  // Length of the deliberate result-side hold-off
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned MaxReports    = 10;
  localparam logic [3:0]  PhaseIdle     = 4'd0;
  // Operation codes past the last defined one; the core must ignore them
  localparam logic [2:0]  OpBadLo       = 3'(OP_CLEAR) + 3'd1;
  localparam logic [2:0]  OpBadHi       = 3'd7;

  // Segment plan of each operation, padded to the longest plan
  localparam seg_e OpPlan [0:4][0:13] = '{
    '{SEG_START, SEG_ADDRW, SEG_ACK, SEG_COND, SEG_B1, SEG_ACK, SEG_STOP,
      SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE},
    '{SEG_START, SEG_ADDRW, SEG_ACK, SEG_COND, SEG_B1, SEG_ACK, SEG_COND,
      SEG_B2, SEG_ACK, SEG_STOP, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE},
    '{SEG_START, SEG_ADDRR, SEG_ACK, SEG_COND, SEG_RDB, SEG_NACK, SEG_STOP,
      SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE},
    '{SEG_START, SEG_ADDRW, SEG_ACK, SEG_COND, SEG_B1, SEG_ACK, SEG_COND,
      SEG_START, SEG_ADDRR, SEG_ACK, SEG_COND, SEG_RDB, SEG_NACK, SEG_STOP},
    '{SEG_CLR, SEG_CHK, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE,
      SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE}
  };
  localparam logic [3:0] PlanLen [0:4] = '{4'd7, 4'd10, 4'd7, 4'd14, 4'd2};

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  cfg_idx_e   cfg_idx_i;
  logic [7:0] cfg_wdata_i;

  i2cseq_stream_if #(.payload_t(req_t)) req_ch ();
  i2cseq_stream_if #(.payload_t(res_t)) res_ch ();

  i2c_master_transaction_sequencer_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .res_o       (res_ch)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Bus sequencer prediction: configuration and a private copy of the state
  // ---------------------------------------------------------------------------
  logic       ign_nak;
  logic [7:0] hold_ticks;

  logic [3:0] seq_phase;   // plan position + 1, zero while idle
  logic [2:0] micro;       // step inside the current segment
  logic [3:0] bit_cnt;
  logic [7:0] shifter;
  logic [7:0] hold_left;
  logic [3:0] loop_cnt;    // completed SCL-low/STOP loops of a bus clear
  logic [2:0] op_q;
  logic [6:0] addr_q;
  logic [7:0] data1;
  logic [7:0] data2;
  logic       ack_status;
  logic [7:0] rd_byte;
  logic       scl_lv;
  logic       sda_lv;

  res_t expected_bus_q [$];

  function automatic void reset_model();
    ign_nak    = 1'b0;
    hold_ticks = 8'd0;
    seq_phase  = PhaseIdle;
    micro      = BIT_DRIVE;
    bit_cnt    = 4'd0;
    shifter    = 8'd0;
    hold_left  = 8'd0;
    loop_cnt   = 4'd0;
    op_q       = 3'd0;
    addr_q     = 7'd0;
    data1      = 8'd0;
    data2      = 8'd0;
    ack_status = 1'b0;
    rd_byte    = 8'd0;
    scl_lv     = 1'b1;
    sda_lv     = 1'b1;
  endfunction

  // Move onto the segment at seq_phase: resolve the NACK checkpoints, then load
  // the shift register for the byte that segment moves.
  function automatic void enter_segment();
    while (OpPlan[op_q][seq_phase - 4'd1] == SEG_COND) begin
      if (!ack_status || ign_nak) begin
        seq_phase++;
      end else begin
        seq_phase = PlanLen[op_q];
      end
    end
    micro    = BIT_DRIVE;
    bit_cnt  = 4'd0;
    loop_cnt = 4'd0;
    case (OpPlan[op_q][seq_phase - 4'd1])
      SEG_ADDRW: shifter = {addr_q, 1'b0};
      SEG_ADDRR: shifter = {addr_q, 1'b1};
      SEG_B1:    shifter = data1;
      SEG_B2:    shifter = data2;
      SEG_RDB:   shifter = 8'd0;
      default: ;
    endcase
  endfunction

  // Perform one line action of segment seg; return 1 when the segment is over.
  function automatic logic segment_step(seg_e seg, logic sda);
    logic       rd;
    logic [3:0] nbits;
    rd    = (seg == SEG_ACK) || (seg == SEG_RDB);
    nbits = (seg == SEG_ACK || seg == SEG_NACK) ? 4'd1 : ByteBits;
    case (seg)
      SEG_START: begin
        case (micro)
          3'd0: sda_lv = 1'b1;
          3'd1: scl_lv = 1'b1;
          3'd2: sda_lv = 1'b0;
          default: begin
            scl_lv = 1'b0;
            return 1'b1;
          end
        endcase
        micro++;
        return 1'b0;
      end
      SEG_STOP: begin
        case (micro)
          3'd0: sda_lv = 1'b0;
          3'd1: scl_lv = 1'b1;
          default: begin
            sda_lv = 1'b1;
            return 1'b1;
          end
        endcase
        micro++;
        return 1'b0;
      end
      SEG_CLR: begin
        case (micro)
          3'd0: scl_lv = 1'b0;
          3'd1: sda_lv = 1'b0;
          3'd2: scl_lv = 1'b1;
          default: begin
            sda_lv = 1'b1;
            loop_cnt++;
            micro = 3'd0;
            return loop_cnt >= ClearLoops;
          end
        endcase
        micro++;
        return 1'b0;
      end
      SEG_CHK: begin
        // A line still held low after the clear is an error
        ack_status = ~sda;
        return 1'b1;
      end
      default: ;
    endcase
    // Bit slots of address, data, read, ACK and NACK segments
    case (micro)
      BIT_DRIVE: begin
        if (rd) begin
          scl_lv = 1'b1;
        end else begin
          sda_lv = (seg == SEG_NACK) ? 1'b1 : shifter[7];
        end
        micro = BIT_SAMPLE;
      end
      BIT_SAMPLE: begin
        if (seg == SEG_ACK) begin
          ack_status = sda;
        end else if (seg == SEG_RDB) begin
          shifter = {shifter[6:0], sda};
        end else begin
          scl_lv = 1'b1;
        end
        hold_left = hold_ticks;
        micro     = (hold_left != 8'd0) ? BIT_HOLD : BIT_LOW;
      end
      BIT_HOLD: begin
        hold_left--;
        if (hold_left == 8'd0) micro = BIT_LOW;
      end
      BIT_LOW: begin
        scl_lv = 1'b0;
        if (!rd) shifter = {shifter[6:0], 1'b0};
        bit_cnt++;
        if (bit_cnt < nbits) begin
          micro = BIT_DRIVE;
        end else if (seg == SEG_RDB) begin
          rd_byte = shifter;
          return 1'b1;
        end else if (seg == SEG_ACK || seg == SEG_NACK) begin
          return 1'b1;
        end else begin
          micro = BIT_RELEASE;
        end
      end
      default: begin
        sda_lv = 1'b1;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // Advance the prediction by one accepted tick and return the expected result
  function automatic res_t bus_tick(req_t t);
    res_t o;
    logic busy;
    logic fin;
    busy = 1'b0;
    fin  = 1'b0;
    if (seq_phase == PhaseIdle && t.request_valid && t.operation <= 3'(OP_CLEAR)) begin
      op_q      = t.operation;
      addr_q    = t.slave_address;
      data1     = t.first_byte;
      data2     = t.second_byte;
      seq_phase = 4'd1;
      enter_segment();
    end
    if (seq_phase != PhaseIdle) begin
      busy = 1'b1;
      if (segment_step(OpPlan[op_q][seq_phase - 4'd1], t.sda_in)) begin
        if (seq_phase >= PlanLen[op_q]) begin
          seq_phase = PhaseIdle;
          micro     = BIT_DRIVE;
          fin       = 1'b1;
        end else begin
          seq_phase++;
          enter_segment();
        end
      end
    end
    o.scl_out   = scl_lv;
    o.sda_out   = sda_lv;
    o.busy_res  = busy;
    o.done_res  = fin;
    o.status    = ack_status;
    o.read_data = rd_byte;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  int unsigned ticks_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  int unsigned burst_left   = 0;
  int unsigned idle_cycles  = 0;
  bit          steady       = 1'b0;  // offer back to back, no sender gaps
  bit          hold_off_req = 1'b0;  // ask the result side for a long stall

  function automatic req_t any_tick();
    logic [31:0] r;
    r = $urandom;
    return r[$bits(req_t)-1:0];
  endfunction

  // SDA level the slave side shows for the next tick. Shape it from the
  // predicted state: ACK slots NACK with fault_pct percent, the bus-clear check
  // sees a stuck line with fault_pct percent, read slots carry rd_val MSB first.
  function automatic logic line_level(logic [7:0] rd_val, int unsigned fault_pct);
    seg_e s;
    if (seq_phase == PhaseIdle) return 1'($urandom_range(0, 1));
    s = OpPlan[op_q][seq_phase - 4'd1];
    if (s == SEG_ACK && micro == BIT_SAMPLE) return $urandom_range(0, 99) < fault_pct;
    if (s == SEG_CHK) return !($urandom_range(0, 99) < fault_pct);
    if (s == SEG_RDB && micro == BIT_SAMPLE) return rd_val[3'd7 - bit_cnt[2:0]];
    return 1'($urandom_range(0, 1));
  endfunction

  // Offer one tick, wait for the handshake, record its expected result, then
  // idle the sender for a while at the end of a burst.
  task automatic send_tick(req_t t);
    req_ch.valid   <= 1'b1;
    req_ch.payload <= t;
    do @(posedge clk_i); while (!req_ch.ready);
    expected_bus_q.push_back(bus_tick(t));
    ticks_sent++;
    if (!steady) begin
      if (burst_left != 0) begin
        burst_left--;
      end else begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = $urandom_range(1, 40);
      end
    end
  endtask

  // Run ticks until the sequencer is idle again; request fields stay random,
  // so requests offered while busy get exercised and ignored.
  task automatic finish_txn(logic [7:0] rd_val, int unsigned fault_pct);
    req_t t;
    while (seq_phase != PhaseIdle) begin
      t        = any_tick();
      t.sda_in = line_level(rd_val, fault_pct);
      send_tick(t);
    end
  endtask

  task automatic run_txn(op_e op, logic [6:0] addr, logic [7:0] b1, logic [7:0] b2,
                         logic [7:0] rd_val, int unsigned fault_pct);
    req_t t;
    finish_txn(8'($urandom), 12);
    t               = any_tick();
    t.request_valid = 1'b1;
    t.operation     = op;
    t.slave_address = addr;
    t.first_byte    = b1;
    t.second_byte   = b2;
    t.sda_in        = line_level(rd_val, fault_pct);
    send_tick(t);
    finish_txn(rd_val, fault_pct);
  endtask

  // Idle ticks: no request, an undefined operation, or anything at all (which
  // may start a transaction that the next run_txn completes first).
  task automatic send_noise();
    req_t t;
    t = any_tick();
    case ($urandom_range(0, 2))
      0: t.request_valid = 1'b0;
      1: begin
        t.request_valid = 1'b1;
        t.operation     = 3'($urandom_range(OpBadLo, OpBadHi));
      end
      default: ;
    endcase
    send_tick(t);
  endtask

  // Hold valid low until every expected result has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (expected_bus_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_IGNORE_NAK) begin
      ign_nak = val[0];
    end else begin
      hold_ticks = val;
    end
    @(posedge clk_i);
  endtask

  task automatic set_mode(logic ign, logic [7:0] hold);
    write_reg(CFG_IGNORE_NAK, {7'd0, ign});
    write_reg(CFG_HIGH_HOLD, hold);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every operation with extreme field values, bus clear on a free and a
  // stuck line, undefined operation codes and ticks without a request.
  task automatic test_each_operation();
    req_t t;
    run_txn(OP_WR1, 7'h7F, 8'hFF, 8'h00, 8'h00, 0);
    run_txn(OP_WR2, 7'h00, 8'h00, 8'hFF, 8'h00, 0);
    run_txn(OP_RD1, 7'h55, 8'h0F, 8'hF0, 8'hFF, 0);
    run_txn(OP_RD1, 7'h2A, 8'hF0, 8'h0F, 8'h00, 0);
    run_txn(OP_WRRD, 7'h7F, 8'hA5, 8'h5A, 8'hC3, 0);
    run_txn(OP_CLEAR, 7'h00, 8'h00, 8'h00, 8'h00, 0);
    run_txn(OP_CLEAR, 7'h7F, 8'hFF, 8'hFF, 8'h00, 100);
    // Undefined codes and an unrequested write must leave the bus alone
    t               = any_tick();
    t.request_valid = 1'b1;
    t.operation     = OpBadLo;
    send_tick(t);
    t.operation     = OpBadHi;
    send_tick(t);
    t.request_valid = 1'b0;
    t.operation     = OP_WR1;
    send_tick(t);
  endtask

  // NACK handling: skip to STOP by default, carry on when ignore_nak is set.
  // A skipped read keeps the previous read byte.
  task automatic test_nak_paths();
    set_mode(1'b0, 8'd0);
    run_txn(OP_WR1, 7'h13, 8'h81, 8'h00, 8'h00, 100);
    run_txn(OP_WR2, 7'h64, 8'h3C, 8'hC3, 8'h00, 100);
    run_txn(OP_RD1, 7'h21, 8'h00, 8'h00, 8'h96, 100);
    run_txn(OP_WRRD, 7'h48, 8'h10, 8'h00, 8'h69, 100);
    run_txn(OP_WRRD, 7'h09, 8'hE7, 8'h00, 8'h7E, 50);
    run_txn(OP_WR2, 7'h5D, 8'h18, 8'h24, 8'h00, 50);
    set_mode(1'b1, 8'd1);
    run_txn(OP_WRRD, 7'h6E, 8'h42, 8'h00, 8'hB5, 100);
    run_txn(OP_RD1, 7'h31, 8'h00, 8'h00, 8'h4B, 100);
    run_txn(OP_WR2, 7'h7A, 8'h99, 8'h66, 8'h00, 100);
    run_txn(OP_CLEAR, 7'h01, 8'h00, 8'h00, 8'h00, 100);
  endtask

  // Random transactions with random content, mostly acknowledged
  task automatic test_random_traffic(logic ign, logic [7:0] hold, int unsigned n_ticks);
    int unsigned first;
    int unsigned fault;
    first = ticks_sent;
    set_mode(ign, hold);
    while (ticks_sent - first < n_ticks) begin
      repeat ($urandom_range(0, 2)) send_noise();
      case ($urandom_range(0, 9))
        0:       fault = 100;
        1, 2:    fault = 0;
        default: fault = 12;
      endcase
      run_txn(op_e'($urandom_range(0, 4)), 7'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), fault);
    end
  endtask

  // Stall the result side for a long stretch while ticks keep coming, so the
  // core fills up and pushes back on the request side.
  task automatic test_receiver_hold_off();
    steady       = 1'b1;
    hold_off_req = 1'b1;
    run_txn(op_e'($urandom_range(0, 4)), 7'($urandom), 8'($urandom), 8'($urandom),
            8'($urandom), 12);
    steady = 1'b0;
  endtask

  // Longest SCL high time: hold the first address bit for the full count,
  // then drop the extra hold for the rest of the transfer.
  task automatic test_hold_extremes();
    req_t t;
    finish_txn(8'($urandom), 12);
    set_mode(1'b0, 8'd255);
    t               = any_tick();
    t.request_valid = 1'b1;
    t.operation     = OP_WR1;
    t.slave_address = 7'($urandom);
    t.first_byte    = 8'($urandom);
    t.sda_in        = line_level(8'h00, 100);
    send_tick(t);
    // Advance until the first address bit starts its hold
    while (!(OpPlan[op_q][seq_phase - 4'd1] == SEG_ADDRW && micro == BIT_HOLD)) begin
      t        = any_tick();
      t.sda_in = line_level(8'h00, 100);
      send_tick(t);
    end
    write_reg(CFG_HIGH_HOLD, 8'd0);
    finish_txn(8'h00, 100);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern, checking and watchdog
  // ---------------------------------------------------------------------------
  int unsigned mode_left = 0;
  int unsigned stall_pct = 0;

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        // Hold off for the full stretch, then go back to the pattern
        res_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            default: stall_pct = 70;
          endcase
          mode_left = $urandom_range(16, 128);
        end
        mode_left--;
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  res_t  want_res;
  res_t  got_res;
  string diff;

  // Compare each accepted result with the oldest expectation, field by field
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got_res = res_ch.payload;
      results_seen++;
      if (expected_bus_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("tick result %0d arrived with nothing expected: %p", results_seen, got_res);
        end
      end else begin
        want_res = expected_bus_q.pop_front();
        diff     = "";
        if (got_res.scl_out !== want_res.scl_out)     diff = {diff, " scl_out"};
        if (got_res.sda_out !== want_res.sda_out)     diff = {diff, " sda_out"};
        if (got_res.busy_res !== want_res.busy_res)   diff = {diff, " busy_res"};
        if (got_res.done_res !== want_res.done_res)   diff = {diff, " done_res"};
        if (got_res.status !== want_res.status)       diff = {diff, " status"};
        if (got_res.read_data !== want_res.read_data) diff = {diff, " read_data"};
        if (diff != "") begin
          errors++;
          if (errors <= MaxReports) begin
            $display("tick result %0d differs in%s", results_seen, diff);
            $display("  expected scl=%b sda=%b busy=%b done=%b status=%b data=%h",
                     want_res.scl_out, want_res.sda_out, want_res.busy_res,
                     want_res.done_res, want_res.status, want_res.read_data);
            $display("  actual   scl=%b sda=%b busy=%b done=%b status=%b data=%h",
                     got_res.scl_out, got_res.sda_out, got_res.busy_res,
                     got_res.done_res, got_res.status, got_res.read_data);
          end
        end
      end
    end
  end

  // Count cycles in which no request moves on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_IGNORE_NAK;
    cfg_wdata_i    <= 8'd0;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    reset_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_each_operation();
    test_nak_paths();
    test_random_traffic(1'b0, 8'd0, 40);
    // One stretch with the sender never idling
    steady = 1'b1;
    test_random_traffic(1'b1, 8'd0, 30);
    steady = 1'b0;
    test_receiver_hold_off();
    test_random_traffic(1'b0, 8'd2, 20);
    test_random_traffic(1'b1, 8'd1, 20);
    test_hold_extremes();

    // Let the last results drain, then wait for anything stray
    drain();
    repeat (20) @(posedge clk_i);
    errors += expected_bus_q.size();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/i2cseq_pkg.sv
rtl/core/i2cseq_stream_if.sv
rtl/core/i2cseq_step.sv
rtl/core/i2c_master_transaction_sequencer_core.sv
sim/tb_i2c_master_transaction_sequencer_core.sv
